/* rtl/idgl_pkg.sv */
`default_nettype none

package idgl_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int CNT_W = $clog2(OPERAND_WIDTH);

	localparam logic [OPERAND_WIDTH-1:0] MAX_POS = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};

	localparam logic [2:0] OP_QUO = 3'd0;
	localparam logic [2:0] OP_REM = 3'd1;
	localparam logic [2:0] OP_MOD = 3'd2;
	localparam logic [2:0] OP_GCD = 3'd3;
	localparam logic [2:0] OP_LCM = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DIVZERO  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// command to the shared shift/add unit
	typedef struct packed {
		logic start;
		logic mul;
	} unit_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_rsp_t;

endpackage

`default_nettype wire

/* rtl/idgl_iter_unit.sv */
`default_nettype none

// One bit per cycle: restoring divide (lo = quotient, hi = remainder)
// or shift-add multiply ({hi, lo} = product), on one shared adder.
module idgl_iter_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire idgl_pkg::unit_cmd_t                  cmd,
	input  wire logic [idgl_pkg::OPERAND_WIDTH-1:0]   opa,
	input  wire logic [idgl_pkg::OPERAND_WIDTH-1:0]   opb,
	output idgl_pkg::unit_rsp_t                       rsp,
	output logic [idgl_pkg::OPERAND_WIDTH-1:0]        hi,
	output logic [idgl_pkg::OPERAND_WIDTH-1:0]        lo
);

	localparam int W = idgl_pkg::OPERAND_WIDTH;

	logic                          busy_q;
	logic                          done_q;
	logic                          mul_q;
	logic [idgl_pkg::CNT_W-1:0]    cnt_q;
	logic [W-1:0]                  hi_q;
	logic [W-1:0]                  lo_q;
	logic [W-1:0]                  opb_q;

	logic [W:0]   shifted;
	logic [W+1:0] add_a;
	logic [W+1:0] add_b;
	logic [W+1:0] sum;
	logic         fits;

	always_comb begin
		shifted = {hi_q, lo_q[W-1]};
		if (mul_q) begin
			add_a = {2'b00, hi_q};
			add_b = lo_q[0] ? {2'b00, opb_q} : '0;
		end else begin
			add_a = {1'b0, shifted};
			add_b = ~{2'b00, opb_q};
		end
		sum  = add_a + add_b + (W+2)'(!mul_q);
		fits = !sum[W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mul_q  <= 1'b0;
			cnt_q  <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
			opb_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == idgl_pkg::CNT_W'(W-1));
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				mul_q  <= cmd.mul;
				cnt_q  <= '0;
				hi_q   <= '0;
				lo_q   <= opa;
				opb_q  <= opb;
			end else if (busy_q) begin
				if (mul_q) begin
					hi_q <= sum[W:1];
					lo_q <= {sum[0], lo_q[W-1:1]};
				end else if (fits) begin
					hi_q <= sum[W-1:0];
					lo_q <= {lo_q[W-2:0], 1'b1};
				end else begin
					hi_q <= shifted[W-1:0];
					lo_q <= {lo_q[W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == idgl_pkg::CNT_W'(W-1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign hi       = hi_q;
	assign lo       = lo_q;

endmodule

`default_nettype wire

/* rtl/integer_divide_gcd_lcm_unit_top.sv */
`default_nettype none

// Channel  Handshake             Word
// in       in_valid / in_ready   opcode, first_operand, second_operand
// out      out_valid / out_ready result_value, status
//
// Every divide or multiply pass runs on the one shared unit (W = 32). Quotient,
// remainder, modulo: one divide pass. GCD: one pass per Euclid step. LCM: the GCD
// steps plus two more. No pass: zero divisor, GCD by zero, LCM of zero, bad opcode.
// in_ready is high only when idle; a finished word waits in the output register
// while the next item is taken. Reset clears sequencer and valid state.
module integer_divide_gcd_lcm_unit_top (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       in_valid,
	output logic                                            in_ready,
	input  wire logic [2:0]                                 opcode,
	input  wire logic signed [idgl_pkg::OPERAND_WIDTH-1:0]  first_operand,
	input  wire logic signed [idgl_pkg::OPERAND_WIDTH-1:0]  second_operand,
	output logic                                            out_valid,
	input  wire logic                                       out_ready,
	output logic signed [idgl_pkg::OPERAND_WIDTH-1:0]       result_value,
	output logic [1:0]                                      status
);

	localparam int W = idgl_pkg::OPERAND_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_GCD,
		S_LCMDIV,
		S_LCMMUL,
		S_PUSH
	} state_t;

	state_t                 state_q;
	logic [2:0]             op_q;
	logic                   na_q;
	logic                   nb_q;
	logic [W-1:0]           ma_q;
	logic [W-1:0]           mb_q;
	logic [W-1:0]           y_q;
	logic [W-1:0]           val_q;
	logic                   vneg_q;
	logic [1:0]             st_q;
	logic                   out_valid_q;
	logic [W-1:0]           result_q;
	logic [1:0]             status_q;
	idgl_pkg::unit_cmd_t    ucmd_q;
	logic [W-1:0]           ua_q;
	logic [W-1:0]           ub_q;

	idgl_pkg::unit_rsp_t    ursp;
	logic [W-1:0]           u_hi;
	logic [W-1:0]           u_lo;

	logic [W-1:0]           a_raw;
	logic [W-1:0]           b_raw;
	logic                   na_d;
	logic                   nb_d;
	logic [W-1:0]           ma_d;
	logic [W-1:0]           mb_d;
	logic                   slot_free;

	idgl_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ucmd_q),
		.opa    (ua_q),
		.opb    (ub_q),
		.rsp    (ursp),
		.hi     (u_hi),
		.lo     (u_lo)
	);

	always_comb begin
		a_raw     = first_operand;
		b_raw     = second_operand;
		na_d      = a_raw[W-1];
		nb_d      = b_raw[W-1];
		ma_d      = na_d ? (~a_raw + 1'b1) : a_raw;
		mb_d      = nb_d ? (~b_raw + 1'b1) : b_raw;
		slot_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			na_q        <= 1'b0;
			nb_q        <= 1'b0;
			ma_q        <= '0;
			mb_q        <= '0;
			y_q         <= '0;
			val_q       <= '0;
			vneg_q      <= 1'b0;
			st_q        <= idgl_pkg::ST_OK;
			out_valid_q <= 1'b0;
			result_q    <= '0;
			status_q    <= idgl_pkg::ST_OK;
			ucmd_q      <= '0;
			ua_q        <= '0;
			ub_q        <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_PUSH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= opcode;
						na_q   <= na_d;
						nb_q   <= nb_d;
						ma_q   <= ma_d;
						mb_q   <= mb_d;
						y_q    <= mb_d;
						vneg_q <= 1'b0;
						ua_q   <= ma_d;
						ub_q   <= mb_d;
						ucmd_q.mul <= 1'b0;
						unique case (opcode)
							idgl_pkg::OP_QUO, idgl_pkg::OP_REM, idgl_pkg::OP_MOD: begin
								val_q <= '0;
								if (mb_d == '0) begin
									st_q         <= idgl_pkg::ST_DIVZERO;
									ucmd_q.start <= 1'b0;
									state_q      <= S_PUSH;
								end else begin
									st_q         <= idgl_pkg::ST_OK;
									ucmd_q.start <= 1'b1;
									state_q      <= S_DIV;
								end
							end
							idgl_pkg::OP_GCD: begin
								if (mb_d == '0) begin
									val_q <= ma_d[W-1] ? idgl_pkg::MAX_POS : ma_d;
									st_q  <= ma_d[W-1] ? idgl_pkg::ST_OVERFLOW
									                   : idgl_pkg::ST_OK;
									ucmd_q.start <= 1'b0;
									state_q      <= S_PUSH;
								end else begin
									val_q        <= '0;
									st_q         <= idgl_pkg::ST_OK;
									ucmd_q.start <= 1'b1;
									state_q      <= S_GCD;
								end
							end
							idgl_pkg::OP_LCM: begin
								val_q <= '0;
								st_q  <= idgl_pkg::ST_OK;
								if (ma_d != '0 && mb_d != '0) begin
									ucmd_q.start <= 1'b1;
									state_q      <= S_GCD;
								end else begin
									ucmd_q.start <= 1'b0;
									state_q      <= S_PUSH;
								end
							end
							default: begin
								val_q        <= '0;
								st_q         <= idgl_pkg::ST_OK;
								ucmd_q.start <= 1'b0;
								state_q      <= S_PUSH;
							end
						endcase
					end else begin
						ucmd_q.start <= 1'b0;
					end
				end
				S_DIV: begin
					ucmd_q.start <= 1'b0;
					if (ursp.done) begin
						state_q <= S_PUSH;
						unique case (op_q)
							idgl_pkg::OP_QUO: begin
								if (na_q == nb_q && u_lo[W-1]) begin
									val_q  <= idgl_pkg::MAX_POS;
									vneg_q <= 1'b0;
									st_q   <= idgl_pkg::ST_OVERFLOW;
								end else begin
									val_q  <= u_lo;
									vneg_q <= na_q ^ nb_q;
								end
							end
							idgl_pkg::OP_MOD: begin
								if (u_hi != '0 && na_q != nb_q) begin
									val_q  <= mb_q - u_hi;
									vneg_q <= nb_q;
								end else begin
									val_q  <= u_hi;
									vneg_q <= na_q;
								end
							end
							default: begin
								val_q  <= u_hi;
								vneg_q <= na_q;
							end
						endcase
					end
				end
				S_GCD: begin
					ucmd_q.start <= ursp.done && (u_hi != '0 || op_q != idgl_pkg::OP_GCD);
					if (ursp.done) begin
						if (u_hi != '0) begin
							ua_q <= y_q;
							ub_q <= u_hi;
							y_q  <= u_hi;
						end else if (op_q == idgl_pkg::OP_GCD) begin
							val_q   <= y_q[W-1] ? idgl_pkg::MAX_POS : y_q;
							st_q    <= y_q[W-1] ? idgl_pkg::ST_OVERFLOW : idgl_pkg::ST_OK;
							state_q <= S_PUSH;
						end else begin
							ua_q    <= ma_q;
							ub_q    <= y_q;
							state_q <= S_LCMDIV;
						end
					end
				end
				S_LCMDIV: begin
					ucmd_q.start <= ursp.done;
					if (ursp.done) begin
						ua_q       <= u_lo;
						ub_q       <= mb_q;
						ucmd_q.mul <= 1'b1;
						state_q    <= S_LCMMUL;
					end
				end
				S_LCMMUL: begin
					ucmd_q.start <= 1'b0;
					if (ursp.done) begin
						if (u_hi != '0 || u_lo[W-1]) begin
							val_q <= idgl_pkg::MAX_POS;
							st_q  <= idgl_pkg::ST_OVERFLOW;
						end else begin
							val_q <= u_lo;
						end
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					ucmd_q.start <= 1'b0;
					if (slot_free) begin
						out_valid_q <= 1'b1;
						result_q    <= vneg_q ? (~val_q + 1'b1) : val_q;
						status_q    <= st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					ucmd_q.start <= 1'b0;
					state_q      <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign status       = status_q;

	a_start_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		ucmd_q.start |-> !ursp.busy)
		else $error("unit started while busy");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		ursp.done |-> (state_q == S_DIV || state_q == S_GCD ||
		               state_q == S_LCMDIV || state_q == S_LCMMUL))
		else $error("unit done with no pass pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	a_divzero_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == idgl_pkg::ST_DIVZERO |-> result_q == '0)
		else $error("zero divisor word not zero");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == idgl_pkg::ST_OVERFLOW |-> result_q == idgl_pkg::MAX_POS)
		else $error("overflow word not saturated");

endmodule

`default_nettype wire

/* bench/idgl_result_checker.sv */
`default_nettype none

module idgl_result_checker (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      in_valid,
	input  wire logic                                      in_ready,
	input  wire logic [2:0]                                opcode,
	input  wire logic signed [idgl_pkg::OPERAND_WIDTH-1:0] first_operand,
	input  wire logic signed [idgl_pkg::OPERAND_WIDTH-1:0] second_operand,
	input  wire logic                                      out_valid,
	input  wire logic                                      out_ready,
	input  wire logic signed [idgl_pkg::OPERAND_WIDTH-1:0] result_value,
	input  wire logic [1:0]                                status,
	output int                                             error_count,
	output int                                             pending_count,
	output int                                             words_checked
);

	import idgl_pkg::*;

	localparam int W = OPERAND_WIDTH;

	typedef struct {
		logic [2:0]          op;
		logic signed [W-1:0] a;
		logic signed [W-1:0] b;
		logic signed [W-1:0] value;
		logic [1:0]          st;
	} awaited_t;

	awaited_t awaited_results[$];

	function automatic logic [W-1:0] magnitude(logic [W-1:0] raw);
		return raw[W-1] ? -raw : raw;
	endfunction

	function automatic logic [W-1:0] signed_word(logic neg, logic [63:0] mag);
		logic [W-1:0] m;
		m = mag[W-1:0];
		return neg ? -m : m;
	endfunction

	function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic awaited_t predict_word(logic [2:0] op, logic [W-1:0] a, logic [W-1:0] b);
		awaited_t    e;
		logic [63:0] ma, mb, q, r, g, part, lim;
		logic        na, nb;
		e.op = op;
		e.a = a;
		e.b = b;
		e.value = '0;
		e.st = ST_OK;
		na = a[W-1];
		nb = b[W-1];
		ma = 64'(magnitude(a));
		mb = 64'(magnitude(b));
		lim = 64'(MAX_POS);
		if (op <= OP_MOD && mb == 0) begin
			e.st = ST_DIVZERO;
		end else begin
			case (op)
				OP_QUO: begin
					q = ma / mb;
					if (na == nb && q > lim) begin
						e.value = MAX_POS;
						e.st = ST_OVERFLOW;
					end else begin
						e.value = signed_word(na != nb, q);
					end
				end
				OP_REM: begin
					e.value = signed_word(na, ma % mb);
				end
				OP_MOD: begin
					r = ma % mb;
					if (r != 0 && na != nb)
						e.value = signed_word(nb, mb - r);
					else
						e.value = signed_word(na, r);
				end
				OP_GCD: begin
					g = euclid_gcd(ma, mb);
					if (g > lim) begin
						e.value = MAX_POS;
						e.st = ST_OVERFLOW;
					end else begin
						e.value = g[W-1:0];
					end
				end
				OP_LCM: begin
					if (ma != 0 && mb != 0) begin
						g = euclid_gcd(ma, mb);
						part = ma / g;
						if (mb > lim / part) begin
							e.value = MAX_POS;
							e.st = ST_OVERFLOW;
						end else begin
							q = part * mb;
							e.value = q[W-1:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		awaited_t e;
		if (!arst_n) begin
			awaited_results.delete();
			error_count <= 0;
			pending_count <= 0;
			words_checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					if (error_count < 10)
						$display("unexpected result word %0d / status %0d at %0t",
							result_value, status, $realtime);
					error_count <= error_count + 1;
				end else begin
					e = awaited_results.pop_front();
					words_checked <= words_checked + 1;
					if (result_value !== e.value || status !== e.st) begin
						if (error_count < 10)
							$display("op %0d a %0d b %0d: expected %0d / %0d, got %0d / %0d",
								e.op, e.a, e.b, e.value, e.st, result_value, status);
						error_count <= error_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(predict_word(opcode, first_operand, second_operand));
			pending_count <= awaited_results.size();
		end
	end

endmodule

`default_nettype wire

/* bench/integer_divide_gcd_lcm_unit_top_tb.sv */
`default_nettype none

module integer_divide_gcd_lcm_unit_top_tb;

	import idgl_pkg::*;

	localparam int W = OPERAND_WIDTH;
	localparam int RANDOM_WORDS = 1200;
	localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MINUS_ONE = '1;
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [2:0]          opcode = OP_QUO;
	logic signed [W-1:0] first_operand = '0;
	logic signed [W-1:0] second_operand = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic signed [W-1:0] result_value;
	logic [1:0]          status;

	int error_count, pending_count, words_checked;
	int gap_level = 0;
	int sent_per_op[8];

	always #6 clk = ~clk;

	integer_divide_gcd_lcm_unit_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_value   (result_value),
		.status         (status)
	);

	idgl_result_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_value   (result_value),
		.status         (status),
		.error_count    (error_count),
		.pending_count  (pending_count),
		.words_checked  (words_checked)
	);

	// receiver stalls in bursts
	initial begin
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 7) < gap_level) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_word(input logic [2:0] op, input logic [W-1:0] a, input logic [W-1:0] b);
		if ($urandom_range(0, 7) < gap_level) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		first_operand <= a;
		second_operand <= b;
		sent_per_op[op]++;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [W-1:0] pick_operand();
		logic [W-1:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: v = MIN_NEG;
					1: v = MAX_POS;
					2: v = '0;
					3: v = 1;
					default: v = MINUS_ONE;
				endcase
			end
			1, 2: v = W'($signed($urandom_range(0, 40)) - 20);
			3, 4, 5: v = W'($urandom);
			default: v = W'($signed(16'($urandom)));
		endcase
		return v;
	endfunction

	initial begin
		logic [2:0]   op;
		logic [W-1:0] a, b, k;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_level = 2;
		send_word(OP_QUO, MIN_NEG, MINUS_ONE);
		send_word(OP_QUO, MIN_NEG, 1);
		send_word(OP_QUO, MAX_POS, MIN_NEG);
		send_word(OP_QUO, MIN_NEG, MIN_NEG);
		send_word(OP_QUO, 7, 0);
		send_word(OP_QUO, -7, 2);
		send_word(OP_REM, -7, 2);
		send_word(OP_REM, MIN_NEG, MINUS_ONE);
		send_word(OP_REM, 5, 0);
		send_word(OP_MOD, -7, 2);
		send_word(OP_MOD, 7, -2);
		send_word(OP_MOD, -6, 3);
		send_word(OP_MOD, MIN_NEG, MINUS_ONE);
		send_word(OP_MOD, 0, 0);
		send_word(OP_GCD, 0, 0);
		send_word(OP_GCD, MIN_NEG, 0);
		send_word(OP_GCD, MIN_NEG, MIN_NEG);
		send_word(OP_GCD, 0, -12);
		send_word(OP_GCD, MIN_NEG, MAX_POS);
		send_word(OP_LCM, 0, 0);
		send_word(OP_LCM, 0, 5);
		send_word(OP_LCM, -4, 6);
		send_word(OP_LCM, MAX_POS, MAX_POS - 1);
		send_word(OP_LCM, MIN_NEG, MIN_NEG);
		send_word(OP_SPARE_LO, MAX_POS, 3);
		send_word(OP_SPARE_HI, -9, MIN_NEG);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 100 == 0)
				gap_level = (i >= RANDOM_WORDS - 150) ? 0 : $urandom_range(0, 3);
			if ($urandom_range(0, 15) == 0)
				op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			else
				op = 3'($urandom_range(OP_QUO, OP_LCM));
			a = pick_operand();
			b = pick_operand();
			// shared factor so gcd and lcm see nontrivial cases
			if (op >= OP_GCD && $urandom_range(0, 9) < 4) begin
				k = W'($urandom_range(1, 300));
				a = k * W'($signed(12'($urandom)));
				b = k * W'($signed(12'($urandom)));
			end
			send_word(op, a, b);
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d words: quotient %0d, remainder %0d, modulo %0d, gcd %0d, lcm %0d",
			RANDOM_WORDS + 26, sent_per_op[OP_QUO], sent_per_op[OP_REM],
			sent_per_op[OP_MOD], sent_per_op[OP_GCD], sent_per_op[OP_LCM]);
		$display("Unused opcodes %0d, results compared %0d",
			sent_per_op[5] + sent_per_op[6] + sent_per_op[7], words_checked);
		if (error_count == 0 && pending_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#120000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
rtl/idgl_pkg.sv
rtl/idgl_iter_unit.sv
rtl/integer_divide_gcd_lcm_unit_top.sv
bench/idgl_result_checker.sv
bench/integer_divide_gcd_lcm_unit_top_tb.sv
